>>> src/cte_pkg.sv
// ============================================================================
// cte_pkg
// Shared types, constants and lookup tables for the calendar-to-epoch unit.
// ============================================================================
package cte_pkg;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned EPOCH_YEAR    = 1970;
    localparam int unsigned MAX_YEAR      = 9999;
    localparam int          ZONE_HOUR_MIN = -12;
    localparam int          ZONE_HOUR_MAX = 14;

    // floor(v / 25) == (v * RECIP25) >> RECIP25_SHIFT for v below 43690
    localparam int unsigned RECIP25       = 5243;
    localparam int unsigned RECIP25_SHIFT = 17;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_DATE = 2'd1,
        STATUS_BAD_TIME = 2'd2,
        STATUS_BAD_ZONE = 2'd3
    } status_t;

    // stage 1 -> stage 2
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [13:0] yrel;       // year - 1970
        logic [11:0] n4;         // (year - 1969) / 4
        logic [24:0] prod4;      // (year / 4) * RECIP25
        logic [22:0] prod16;     // (year / 16) * RECIP25
        logic [24:0] prod100;    // ((year - 1901) / 4) * RECIP25
        logic [22:0] prod400;    // ((year - 1601) / 16) * RECIP25
        logic        year_bad;
        logic        time_bad;
        logic        zone_bad;
        logic [18:0] sec_part;   // time of day minus zone offset, signed
    } front_t;

    // stage 2 -> stage 3
    typedef struct packed {
        logic [21:0] days;
        status_t     status;
        logic [18:0] sec_part;
    } date_t;

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
        logic [4:0] len;
        unique case (month)
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic leap, input logic [3:0] month);
        logic [8:0] base;
        logic [8:0] adj;
        unique case (month)
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        adj = (leap && month > 4'd2 && month <= 4'd12) ? 9'd1 : 9'd0;
        return base + adj;
    endfunction

endpackage

>>> src/calendar_to_epoch_seconds_unit.sv
// ============================================================================
// calendar_to_epoch_seconds_unit
// UTC date, time and zone offset to POSIX seconds since 1970-01-01.
// ============================================================================
// A transaction is taken on every clock edge with start high; busy is never
// raised, so one conversion can be issued every cycle. The result appears on
// epoch_seconds/status with done high for exactly one cycle, once the
// transaction has passed the registers of cte_front, cte_date and cte_scale.
// Results come out in issue order. The receiver cannot stall the four-stage
// pipeline (field checks and reciprocal products, leap rule and day count,
// day-to-second multiply, final add), which has no hold path.
// status: 0 ok, 1 bad date (year outside 1970..9999, month or day out of
// range), 2 bad time, 3 bad zone; the first failing check wins and forces
// epoch_seconds to 0. epoch_seconds is two's complement (small negative values
// are possible for the first hours of 1970 in east-of-UTC zones).
// ============================================================================
module calendar_to_epoch_seconds_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [13:0]          cal_year,
    input  logic [3:0]           cal_month,
    input  logic [4:0]           cal_day,
    input  logic [4:0]           clock_hour,
    input  logic [5:0]           clock_minute,
    input  logic [5:0]           clock_second,
    input  logic signed [4:0]    zone_hour,
    input  logic [5:0]           zone_minute,
    output logic                 done,
    output logic signed [38:0]   epoch_seconds,
    output logic [1:0]           status
);

    logic             accept;
    logic             s1_valid;
    cte_pkg::front_t  s1_data;
    logic             s2_valid;
    cte_pkg::date_t   s2_data;
    logic [38:0]      epoch_raw;

    // fully pipelined, never back-pressures
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // stage 1: range checks, zone offset, reciprocal products for /100, /400
    cte_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .cal_year     (cal_year),
        .cal_month    (cal_month),
        .cal_day      (cal_day),
        .clock_hour   (clock_hour),
        .clock_minute (clock_minute),
        .clock_second (clock_second),
        .zone_hour    (zone_hour),
        .zone_minute  (zone_minute),
        .out_valid    (s1_valid),
        .out_data     (s1_data)
    );

    // stage 2: leap year, day-of-month check, days since epoch, status priority
    cte_date u_date
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_data  (s2_data)
    );

    // stages 3-4: days * 86400, plus time of day minus zone, zero on error
    cte_scale u_scale
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s2_valid),
        .in_data       (s2_data),
        .out_valid     (done),
        .epoch_seconds (epoch_raw),
        .status        (status)
    );

    assign epoch_seconds = $signed(epoch_raw);

endmodule

>>> src/cte_front.sv
// ============================================================================
// cte_front
// Stage 1: field checks, zone offset, time of day, reciprocal products.
// ============================================================================
module cte_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [13:0]          cal_year,
    input  logic [3:0]           cal_month,
    input  logic [4:0]           cal_day,
    input  logic [4:0]           clock_hour,
    input  logic [5:0]           clock_minute,
    input  logic [5:0]           clock_second,
    input  logic signed [4:0]    zone_hour,
    input  logic [5:0]           zone_minute,
    output logic                 out_valid,
    output cte_pkg::front_t      out_data
);

    logic             valid_reg;
    cte_pkg::front_t  data_reg;
    cte_pkg::front_t  data_next;

    logic [13:0] d1969;
    logic [13:0] d1901;
    logic [13:0] d1601;
    logic [4:0]  habs;
    logic [16:0] zmag;
    logic [16:0] tod;
    logic        zmin_step;
    logic        zone_ok;

    always_comb
    begin
        d1969 = cal_year - 14'd1969;
        d1901 = cal_year - 14'd1901;
        d1601 = cal_year - 14'd1601;

        habs = zone_hour[4] ? 5'(-zone_hour) : zone_hour;
        zmag = 17'(17'(habs) * 17'(cte_pkg::SECS_PER_HOUR))
             + 17'(17'(zone_minute) * 17'(cte_pkg::SECS_PER_MIN));
        tod  = 17'(17'(clock_hour) * 17'(cte_pkg::SECS_PER_HOUR))
             + 17'(17'(clock_minute) * 17'(cte_pkg::SECS_PER_MIN))
             + 17'(clock_second);

        zmin_step = (zone_minute == 6'd0) || (zone_minute == 6'd15) ||
                    (zone_minute == 6'd30) || (zone_minute == 6'd45) ||
                    (zone_minute == 6'd60);
        zone_ok = ((int'(zone_hour) > cte_pkg::ZONE_HOUR_MIN) &&
                   (int'(zone_hour) < cte_pkg::ZONE_HOUR_MAX) && zmin_step) ||
                  (((int'(zone_hour) == cte_pkg::ZONE_HOUR_MIN) ||
                    (int'(zone_hour) == cte_pkg::ZONE_HOUR_MAX)) &&
                   (zone_minute == 6'd0));

        data_next.year     = cal_year;
        data_next.month    = cal_month;
        data_next.day      = cal_day;
        data_next.yrel     = cal_year - 14'(cte_pkg::EPOCH_YEAR);
        data_next.n4       = d1969[13:2];
        data_next.prod4    = 25'(cal_year[13:2]) * 25'(cte_pkg::RECIP25);
        data_next.prod16   = 23'(cal_year[13:4]) * 23'(cte_pkg::RECIP25);
        data_next.prod100  = 25'(d1901[13:2]) * 25'(cte_pkg::RECIP25);
        data_next.prod400  = 23'(d1601[13:4]) * 23'(cte_pkg::RECIP25);
        data_next.year_bad = (cal_year < 14'(cte_pkg::EPOCH_YEAR)) ||
                             (cal_year > 14'(cte_pkg::MAX_YEAR));
        data_next.time_bad = (clock_hour >= 5'd24) || (clock_minute >= 6'd60) ||
                             (clock_second >= 6'd60);
        data_next.zone_bad = !zone_ok;
        // offset carries the sign of zone_hour; subtract it from time of day
        data_next.sec_part = zone_hour[4] ? (19'(tod) + 19'(zmag)) : (19'(tod) - 19'(zmag));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> src/cte_date.sv
// ============================================================================
// cte_date
// Stage 2: leap rule, month/day check, day count since the epoch, status.
// ============================================================================
module cte_date
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  cte_pkg::front_t      in_data,
    output logic                 out_valid,
    output cte_pkg::date_t       out_data
);

    logic            valid_reg;
    cte_pkg::date_t  data_reg;
    cte_pkg::date_t  data_next;

    logic [7:0]  q4;
    logic [5:0]  q16;
    logic [7:0]  n100;
    logic [5:0]  n400;
    logic        r4_zero;
    logic        r16_zero;
    logic        leap;
    logic        date_bad;
    logic [8:0]  ydays;
    logic [22:0] year_days;

    always_comb
    begin
        q4   = in_data.prod4[24:17];
        q16  = in_data.prod16[22:17];
        n100 = in_data.prod100[24:17];
        n400 = in_data.prod400[22:17];

        r4_zero  = (in_data.year[13:2] == 12'(12'(q4) * 12'd25));
        r16_zero = (in_data.year[13:4] == 10'(10'(q16) * 10'd25));
        // year%100 == 0 iff year%4 == 0 and (year/4)%25 == 0; same for 400 with 16
        leap = ((in_data.year[1:0] == 2'd0) && !r4_zero) ||
               ((in_data.year[3:0] == 4'd0) && r16_zero);

        date_bad = in_data.year_bad || (in_data.month == 4'd0) || (in_data.month > 4'd12) ||
                   (in_data.day == 5'd0) ||
                   (in_data.day > cte_pkg::month_len(leap, in_data.month));

        ydays     = cte_pkg::days_before(leap, in_data.month);
        year_days = 23'(in_data.yrel) * 23'(cte_pkg::DAYS_PER_YEAR);

        data_next.days = 22'(year_days) + 22'(ydays) + 22'(in_data.day) - 22'd1
                       + 22'(in_data.n4) - 22'(n100) + 22'(n400);

        if (date_bad)
            data_next.status = cte_pkg::STATUS_BAD_DATE;
        else if (in_data.time_bad)
            data_next.status = cte_pkg::STATUS_BAD_TIME;
        else if (in_data.zone_bad)
            data_next.status = cte_pkg::STATUS_BAD_ZONE;
        else
            data_next.status = cte_pkg::STATUS_OK;

        data_next.sec_part = in_data.sec_part;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> src/cte_scale.sv
// ============================================================================
// cte_scale
// Stages 3 and 4: days to seconds, add time of day, zero on error.
// ============================================================================
module cte_scale
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  cte_pkg::date_t       in_data,
    output logic                 out_valid,
    output logic [38:0]          epoch_seconds,
    output logic [1:0]           status
);

    logic              mul_valid_reg;
    logic [38:0]       prod_reg;
    logic [38:0]       prod_next;
    cte_pkg::status_t  mul_status_reg;
    logic [18:0]       mul_sec_reg;

    logic              out_valid_reg;
    logic [38:0]       epoch_reg;
    logic [38:0]       epoch_next;
    cte_pkg::status_t  status_reg;

    assign prod_next = 39'(in_data.days) * 39'(cte_pkg::SECS_PER_DAY);

    always_comb
    begin
        if (mul_status_reg != cte_pkg::STATUS_OK)
            epoch_next = 39'd0;
        else
            epoch_next = prod_reg + {{20{mul_sec_reg[18]}}, mul_sec_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= in_valid;
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        mul_status_reg <= in_data.status;
        mul_sec_reg    <= in_data.sec_part;
        epoch_reg      <= epoch_next;
        status_reg     <= mul_status_reg;
    end

    assign out_valid     = out_valid_reg;
    assign epoch_seconds = epoch_reg;
    assign status        = status_reg;

endmodule
